// ----- rtl/rtta_pkg.sv -----
// Shared types and constants for the rotated, tiled texel address map.
// No dependencies; every other file of the block imports this package.
package rtta_pkg;

    localparam int COORD_W   = 13;  // pixel and source coordinates
    localparam int DIM_W     = 14;  // stored sizes and placed coordinates
    localparam int ORG_W     = 15;  // signed placement origin
    localparam int NUM_W     = 15;  // magnitude of a placed coordinate
    localparam int IDX_W     = 26;  // linear texel indices
    localparam int CFG_W     = 15;  // configuration write data
    localparam int CFG_IDX_W = 3;   // configuration register index
    localparam int MODE_W    = 4;

    // Remainder unit: one bit of the magnitude per step
    localparam int REM_STAGES = 3;
    localparam int REM_STEPS  = NUM_W / REM_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X       = 3'd0,
        CFG_ORIGIN_Y       = 3'd1,
        CFG_SOURCE_WIDTH   = 3'd2,
        CFG_SOURCE_HEIGHT  = 3'd3,
        CFG_SHEET_WIDTH    = 3'd4,
        CFG_PLACEMENT_MODE = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    // Placement mode bit positions
    localparam int MODE_TILE_H = 2;
    localparam int MODE_TILE_V = 3;

    // One lane of the remainder unit: dividend bits still to shift in,
    // and the partial remainder so far
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DIM_W-1:0] rem;
    } t_rem_lane;

    // Per-item sideband carried beside the remainder lanes
    typedef struct packed {
        logic             hit;
        logic             neg_u;
        logic             neg_v;
        logic [IDX_W-1:0] dst;
    } t_side;

endpackage

// ----- rtl/rtta_rem_stage.sv -----
// One registered stage of the restoring remainder unit (REM_STEPS steps).
// Depends on rtta_pkg for the lane struct and widths.
module rtta_rem_stage (
    input  logic              i_clk,
    input  logic              i_en,
    input  rtta_pkg::t_rem_lane i_lane,
    input  logic [rtta_pkg::DIM_W-1:0] i_div,
    output rtta_pkg::t_rem_lane o_lane
);
    import rtta_pkg::*;

    t_rem_lane        r_lane;
    t_rem_lane        n_lane;
    logic [DIM_W:0]   w_trial;

    // Shift in one dividend bit per step, subtract the divisor when it fits
    always_comb begin
        n_lane  = i_lane;
        w_trial = '0;
        for (int s = 0; s < REM_STEPS; s++) begin
            w_trial = {n_lane.rem, n_lane.num[NUM_W-1]};
            if (w_trial >= {1'b0, i_div}) begin
                w_trial = w_trial - {1'b0, i_div};
            end
            n_lane.rem = w_trial[DIM_W-1:0];
            n_lane.num = {n_lane.num[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- rtl/rotated_tiled_texel_address_map.sv -----
// Top level of the rotated, tiled texel address map.
// Depends on rtta_pkg and rtta_rem_stage (remainder pipeline lanes).
//
// Maps one destination sheet pixel to a source texel per clock unless the output
// stalls: subtract the placement origin, wrap (true modulo) or range-check each
// axis against the placed size, turn by a clockwise quarter rotation, and form
// the linear source and destination indices. Throughput is one item per cycle
// while the output is not stalled. There are nine register stages: origin
// subtract, magnitude with range check and destination product, the remainder
// unit (three stages of five restoring steps per axis), a fix-up stage, the
// rotation stage, the source row multiplier, and the output register with the
// final source index add. The pipeline advances per stage, so bubbles collapse
// and input is stalled only when every stage holds an item and the output is
// stalled. Configuration is written with i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write it only while the block is idle; the block itself does not
// enforce. Zero sizes read as one, sizes over MAX_DIM saturate (at most 16383).
module rotated_tiled_texel_address_map #(
    parameter int MAX_DIM = 8192
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rtta_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtta_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rtta_pkg::COORD_W-1:0]      i_pixel_x,
    input  logic [rtta_pkg::COORD_W-1:0]      i_pixel_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_write_enable,
    output logic [rtta_pkg::COORD_W-1:0]      o_src_x,
    output logic [rtta_pkg::COORD_W-1:0]      o_src_y,
    output logic [rtta_pkg::IDX_W-1:0]        o_src_index,
    output logic [rtta_pkg::IDX_W-1:0]        o_dst_index
);
    import rtta_pkg::*;

    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM > 16383) ? 14'd16383 : DIM_W'(MAX_DIM);

    localparam int S_A  = 0;
    localparam int S_B  = 1;
    localparam int S_C  = 2;
    localparam int S_F  = S_C + REM_STAGES;
    localparam int S_G  = S_F + 1;
    localparam int S_H  = S_G + 1;
    localparam int S_O  = S_H + 1;
    localparam int NSTG = S_O + 1;

    // ---------------- configuration registers ----------------
    logic [ORG_W-1:0]  r_origin_x;
    logic [ORG_W-1:0]  r_origin_y;
    logic [DIM_W-1:0]  r_src_w;
    logic [DIM_W-1:0]  r_src_h;
    logic [DIM_W-1:0]  r_sheet_w;
    logic [MODE_W-1:0] r_mode;
    logic [DIM_W-1:0]  w_cfg_dim;

    always_comb begin
        w_cfg_dim = i_cfg_data[DIM_W-1:0];
        if (w_cfg_dim == '0) begin
            w_cfg_dim = DIM_W'(1);
        end else if (w_cfg_dim > DIM_CAP) begin
            w_cfg_dim = DIM_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_src_w    <= DIM_W'(1);
            r_src_h    <= DIM_W'(1);
            r_sheet_w  <= DIM_W'(1);
            r_mode     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:       r_origin_x <= i_cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y:       r_origin_y <= i_cfg_data[ORG_W-1:0];
                CFG_SOURCE_WIDTH:   r_src_w    <= w_cfg_dim;
                CFG_SOURCE_HEIGHT:  r_src_h    <= w_cfg_dim;
                CFG_SHEET_WIDTH:    r_sheet_w  <= w_cfg_dim;
                CFG_PLACEMENT_MODE: r_mode     <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    logic             w_tile_h;
    logic             w_tile_v;
    logic             w_swap;
    logic [DIM_W-1:0] w_pw;
    logic [DIM_W-1:0] w_ph;

    assign w_tile_h = r_mode[MODE_TILE_H];
    assign w_tile_v = r_mode[MODE_TILE_V];
    assign w_swap   = (r_mode[1:0] == ROT_90) || (r_mode[1:0] == ROT_270);
    assign w_pw     = w_swap ? r_src_h : r_src_w;
    assign w_ph     = w_swap ? r_src_w : r_src_h;

    // ---------------- stage control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    // A stage loads when it is empty or its content moves on
    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_in_stall = !w_rdy[S_A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[S_A]) begin
                r_v[S_A] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage A: subtract origin ----------------
    logic [COORD_W-1:0]       r_a_px;
    logic [COORD_W-1:0]       r_a_py;
    logic signed [NUM_W:0]    r_a_u;
    logic signed [NUM_W:0]    r_a_v;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_A]) begin
            r_a_px <= i_pixel_x;
            r_a_py <= i_pixel_y;
            r_a_u  <= $signed({3'b000, i_pixel_x}) - $signed({r_origin_x[ORG_W-1], r_origin_x});
            r_a_v  <= $signed({3'b000, i_pixel_y}) - $signed({r_origin_y[ORG_W-1], r_origin_y});
        end
    end

    // ---------------- stage B: magnitude, range check, dst product ----------------
    t_rem_lane              r_b_lane_u;
    t_rem_lane              r_b_lane_v;
    logic                   r_b_hit;
    logic                   r_b_neg_u;
    logic                   r_b_neg_v;
    logic [COORD_W-1:0]     r_b_px;
    logic [IDX_W-1:0]       r_b_dprod;
    logic [NUM_W:0]         w_b_abs_u;
    logic [NUM_W:0]         w_b_abs_v;
    logic                   w_b_miss_u;
    logic                   w_b_miss_v;
    logic [COORD_W+DIM_W-1:0] w_b_dprod;

    assign w_b_abs_u  = r_a_u[NUM_W] ? 16'(-r_a_u) : 16'(r_a_u);
    assign w_b_abs_v  = r_a_v[NUM_W] ? 16'(-r_a_v) : 16'(r_a_v);
    assign w_b_miss_u = !w_tile_h && (r_a_u[NUM_W] || (r_a_u[NUM_W-1:0] >= {1'b0, w_pw}));
    assign w_b_miss_v = !w_tile_v && (r_a_v[NUM_W] || (r_a_v[NUM_W-1:0] >= {1'b0, w_ph}));
    assign w_b_dprod  = r_a_py * r_sheet_w;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_B]) begin
            r_b_lane_u.num <= w_b_abs_u[NUM_W-1:0];
            r_b_lane_u.rem <= '0;
            r_b_lane_v.num <= w_b_abs_v[NUM_W-1:0];
            r_b_lane_v.rem <= '0;
            r_b_hit        <= !w_b_miss_u && !w_b_miss_v;
            r_b_neg_u      <= r_a_u[NUM_W];
            r_b_neg_v      <= r_a_v[NUM_W];
            r_b_px         <= r_a_px;
            r_b_dprod      <= w_b_dprod[IDX_W-1:0];
        end
    end

    // ---------------- stages C..E: remainder by placed size ----------------
    t_rem_lane w_u_lane [REM_STAGES+1];
    t_rem_lane w_v_lane [REM_STAGES+1];
    t_side     r_rem_side [REM_STAGES];

    assign w_u_lane[0] = r_b_lane_u;
    assign w_v_lane[0] = r_b_lane_v;

    for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
        rtta_rem_stage u_rem_u (
            .i_clk  (i_clk),
            .i_en   (w_rdy[S_C+g]),
            .i_lane (w_u_lane[g]),
            .i_div  (w_pw),
            .o_lane (w_u_lane[g+1])
        );
        rtta_rem_stage u_rem_v (
            .i_clk  (i_clk),
            .i_en   (w_rdy[S_C+g]),
            .i_lane (w_v_lane[g]),
            .i_div  (w_ph),
            .o_lane (w_v_lane[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_C]) begin
            r_rem_side[0].hit   <= r_b_hit;
            r_rem_side[0].neg_u <= r_b_neg_u;
            r_rem_side[0].neg_v <= r_b_neg_v;
            r_rem_side[0].dst   <= r_b_dprod + {{(IDX_W-COORD_W){1'b0}}, r_b_px};
        end
        for (int k = 1; k < REM_STAGES; k++) begin
            if (w_rdy[S_C+k]) begin
                r_rem_side[k] <= r_rem_side[k-1];
            end
        end
    end

    // ---------------- stage F: fold negative remainders ----------------
    logic [DIM_W-1:0] r_f_u;
    logic [DIM_W-1:0] r_f_v;
    t_side            r_f_side;
    logic [DIM_W-1:0] w_f_rem_u;
    logic [DIM_W-1:0] w_f_rem_v;

    assign w_f_rem_u = w_u_lane[REM_STAGES].rem;
    assign w_f_rem_v = w_v_lane[REM_STAGES].rem;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_F]) begin
            r_f_u    <= (r_rem_side[REM_STAGES-1].neg_u && (w_f_rem_u != '0))
                        ? w_pw - w_f_rem_u : w_f_rem_u;
            r_f_v    <= (r_rem_side[REM_STAGES-1].neg_v && (w_f_rem_v != '0))
                        ? w_ph - w_f_rem_v : w_f_rem_v;
            r_f_side <= r_rem_side[REM_STAGES-1];
        end
    end

    // ---------------- stage G: quarter-turn rotation ----------------
    logic [DIM_W-1:0] r_g_sx;
    logic [DIM_W-1:0] r_g_sy;
    t_side            r_g_side;
    logic [DIM_W-1:0] w_g_sx;
    logic [DIM_W-1:0] w_g_sy;

    always_comb begin
        case (t_rot'(r_mode[1:0]))
            ROT_0: begin
                w_g_sx = r_f_u;
                w_g_sy = r_f_v;
            end
            ROT_90: begin
                w_g_sx = r_f_v;
                w_g_sy = r_src_h - DIM_W'(1) - r_f_u;
            end
            ROT_180: begin
                w_g_sx = r_src_w - DIM_W'(1) - r_f_u;
                w_g_sy = r_src_h - DIM_W'(1) - r_f_v;
            end
            ROT_270: begin
                w_g_sx = r_src_w - DIM_W'(1) - r_f_v;
                w_g_sy = r_f_u;
            end
            default: begin
                w_g_sx = r_f_u;
                w_g_sy = r_f_v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_G]) begin
            r_g_sx   <= w_g_sx;
            r_g_sy   <= w_g_sy;
            r_g_side <= r_f_side;
        end
    end

    // ---------------- stage H: row product ----------------
    logic [DIM_W-1:0]   r_h_sx;
    logic [DIM_W-1:0]   r_h_sy;
    logic [IDX_W-1:0]   r_h_prod;
    t_side              r_h_side;
    logic [2*DIM_W-1:0] w_h_prod;

    assign w_h_prod = r_g_sy * r_src_w;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_H]) begin
            r_h_sx   <= r_g_sx;
            r_h_sy   <= r_g_sy;
            r_h_prod <= w_h_prod[IDX_W-1:0];
            r_h_side <= r_g_side;
        end
    end

    // ---------------- stage O: output register ----------------
    logic               r_o_we;
    logic [COORD_W-1:0] r_o_sx;
    logic [COORD_W-1:0] r_o_sy;
    logic [IDX_W-1:0]   r_o_src;
    logic [IDX_W-1:0]   r_o_dst;

    // Zero the source fields of a skipped pixel
    always_ff @(posedge i_clk) begin
        if (w_rdy[S_O]) begin
            r_o_we  <= r_h_side.hit;
            r_o_sx  <= r_h_side.hit ? r_h_sx[COORD_W-1:0] : '0;
            r_o_sy  <= r_h_side.hit ? r_h_sy[COORD_W-1:0] : '0;
            r_o_src <= r_h_side.hit
                       ? r_h_prod + {{(IDX_W-DIM_W){1'b0}}, r_h_sx} : '0;
            r_o_dst <= r_h_side.dst;
        end
    end

    assign o_out_valid    = r_v[S_O];
    assign o_write_enable = r_o_we;
    assign o_src_x        = r_o_sx;
    assign o_src_y        = r_o_sy;
    assign o_src_index    = r_o_src;
    assign o_dst_index    = r_o_dst;

`ifndef SYNTHESIS
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_enable |->
            (o_src_x == '0) && (o_src_y == '0) && (o_src_index == '0))
        else $error("skipped pixel carries nonzero source fields");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v) && i_out_stall)
        else $error("input stalled while a stage is free");

    a_placed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_F] && r_f_side.hit |-> (r_f_u < w_pw) && (r_f_v < w_ph))
        else $error("placed coordinate outside placed size");
`endif

endmodule
